>>> rtl/wms2d_pkg.sv
// Package for the 2D waypoint step unit: widths, register indexes, reset values
// and the opcode. Used by every file under rtl.
package wms2d_pkg;
  localparam int unsigned PosW  = 32;
  localparam int unsigned VelW  = 17;
  localparam int unsigned SpdW  = 16;
  localparam int unsigned TolW  = 24;
  localparam int unsigned TickW = 16;
  localparam int unsigned DiffW = 33;
  localparam int unsigned RootW = 33;
  localparam int unsigned RemW  = 36;
  localparam int unsigned NumW  = 49;
  localparam int unsigned QW    = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 24;

  localparam logic [CfgIdxW-1:0] RegSpeed = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTol   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTick  = 2'd2;

  localparam logic [SpdW-1:0]  SpeedRst = 16'd256;
  localparam logic [TolW-1:0]  TolRst   = 24'd128;
  localparam logic [TickW-1:0] TickRst  = 16'd655;

  localparam logic OpStep = 1'b0;
  localparam logic OpLoad = 1'b1;
endpackage

>>> rtl/wms2d_div.sv
// Bit-serial restoring divider: 49-bit numerator over 33-bit divisor, 17-bit
// quotient (quotient is known to fit). Depends on wms2d_pkg.
module wms2d_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wms2d_pkg::NumW-1:0]    num_i,
  input  logic [wms2d_pkg::RootW-1:0]   den_i,
  output logic                          done_o,
  output logic [wms2d_pkg::QW-1:0]      quo_o
);
  logic [wms2d_pkg::NumW-1:0]  num_q, num_d;
  logic [wms2d_pkg::RootW:0]   rem_q, rem_d;
  logic [wms2d_pkg::RootW-1:0] den_q;
  logic [wms2d_pkg::QW-1:0]    quo_q, quo_d;
  logic [5:0]                  cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic [wms2d_pkg::RootW+1:0] sh;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh     = {rem_q, num_q[wms2d_pkg::NumW-1]};
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'(wms2d_pkg::NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (sh >= {1'b0, 1'b0, den_q}) begin
        rem_d = (wms2d_pkg::RootW+1)'(sh - {2'b0, den_q});
        quo_d = {quo_q[wms2d_pkg::QW-2:0], 1'b1};
      end else begin
        rem_d = sh[wms2d_pkg::RootW:0];
        quo_d = {quo_q[wms2d_pkg::QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

>>> rtl/waypoint_move_step_2d_unit.sv
// Top level of the 2D waypoint step unit: sequencer, shared 33x33 multiplier, serial
// square root and one shared serial divider. Depends on wms2d_pkg and wms2d_div.
// A load word goes straight to the result; a step word runs the square root and, unless
// it arrives, four divisions in turn through the one divider.
// One word at a time: s_axis_tready rises the cycle after the result word is taken.
// Reset (rst_ni low, async) clears position and velocity; speed 1.0, tol 0.5, tick 655.
module waypoint_move_step_2d_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // target_x[31:0], target_y[63:32]
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [103:0] m_axis_tdata,  // position_x, position_y, velocity_x, velocity_y
  output logic        m_axis_tuser,   // arrived
  input  logic        cfg_we_i,
  input  logic [wms2d_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [wms2d_pkg::CfgDatW-1:0] cfg_data_i
);
  typedef enum logic [3:0] {
    StIdle, StSqX, StSqY, StRoot, StStep, StDecide, StDiv, StDivWait, StOut
  } state_e;

  state_e state_q;
  logic [wms2d_pkg::SpdW-1:0]  speed_q;
  logic [wms2d_pkg::TolW-1:0]  tol_q;
  logic [wms2d_pkg::TickW-1:0] tick_q;
  logic signed [wms2d_pkg::PosW-1:0] pos_x_q, pos_y_q, tx_q, ty_q;
  logic signed [wms2d_pkg::VelW-1:0] vel_x_q, vel_y_q;
  logic [wms2d_pkg::DiffW-1:0] ax_q, ay_q;
  logic        nx_q, ny_q, arrived_q;
  logic [65:0] sum_q;
  logic [wms2d_pkg::RootW-1:0] root_q;
  logic [wms2d_pkg::RemW-1:0]  rem_q;
  logic [5:0]  it_q;
  logic [wms2d_pkg::SpdW-1:0]  stp_q;
  logic [1:0]  dsel_q;
  logic signed [wms2d_pkg::PosW-1:0] dpx_q, dpy_q;

  logic [wms2d_pkg::DiffW-1:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic [wms2d_pkg::RemW-1:0] rem_sh, trial;
  logic [1:0] pair;
  logic        div_start, div_done;
  logic [wms2d_pkg::NumW-1:0] div_num;
  logic [wms2d_pkg::QW-1:0]  div_q;
  logic [wms2d_pkg::DiffW-1:0] dmag;
  logic [wms2d_pkg::SpdW-1:0]  dk;
  logic        dneg;
  logic signed [wms2d_pkg::PosW-1:0] qs;

  always_comb begin
    mul_a = ax_q;
    mul_b = ax_q;
    case (state_q)
      StSqY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      StStep: begin
        mul_a = {17'b0, speed_q};
        mul_b = {17'b0, tick_q};
      end
      StDiv: begin
        mul_a = dmag;
        mul_b = {17'b0, dk};
      end
      default: ;
    endcase
  end
  assign mul_p = {mul_a, 33'b0} == '0 ? '0 : 66'(mul_a) * 66'(mul_b);

  always_comb begin
    dmag = dsel_q[0] ? ay_q : ax_q;
    dneg = dsel_q[0] ? ny_q : nx_q;
    dk   = dsel_q[1] ? speed_q : stp_q;
  end
  assign div_num   = wms2d_pkg::NumW'(mul_p);
  assign div_start = (state_q == StDiv);
  assign qs = dneg ? -wms2d_pkg::PosW'(div_q) : wms2d_pkg::PosW'(div_q);

  assign pair   = (it_q == 6'd32) ? sum_q[65:64] : sum_q[63:62];
  assign rem_sh = {rem_q[wms2d_pkg::RemW-3:0], pair};
  assign trial  = {1'b0, root_q, 2'b01};

  wms2d_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (root_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      speed_q   <= wms2d_pkg::SpeedRst;
      tol_q     <= wms2d_pkg::TolRst;
      tick_q    <= wms2d_pkg::TickRst;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      vel_x_q   <= '0;
      vel_y_q   <= '0;
      arrived_q <= 1'b0;
      it_q      <= '0;
      dsel_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wms2d_pkg::RegSpeed: speed_q <= cfg_data_i[wms2d_pkg::SpdW-1:0];
          wms2d_pkg::RegTol:   tol_q   <= cfg_data_i;
          wms2d_pkg::RegTick:  tick_q  <= cfg_data_i[wms2d_pkg::TickW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: if (s_axis_tvalid) begin
          tx_q <= s_axis_tdata[31:0];
          ty_q <= s_axis_tdata[63:32];
          if (s_axis_tuser == wms2d_pkg::OpLoad) begin
            pos_x_q   <= s_axis_tdata[31:0];
            pos_y_q   <= s_axis_tdata[63:32];
            arrived_q <= 1'b0;
            state_q   <= StOut;
          end else begin
            begin : diff
              logic signed [wms2d_pkg::DiffW-1:0] ex, ey;
              ex = {s_axis_tdata[31], s_axis_tdata[31:0]} - {pos_x_q[31], pos_x_q};
              ey = {s_axis_tdata[63], s_axis_tdata[63:32]} - {pos_y_q[31], pos_y_q};
              nx_q <= ex[32];
              ny_q <= ey[32];
              ax_q <= ex[32] ? -ex : ex;
              ay_q <= ey[32] ? -ey : ey;
            end
            state_q <= StSqX;
          end
        end
        StSqX: begin
          sum_q   <= mul_p;
          state_q <= StSqY;
        end
        StSqY: begin
          sum_q   <= sum_q + mul_p;
          root_q  <= '0;
          rem_q   <= '0;
          it_q    <= 6'd32;
          state_q <= StRoot;
        end
        StRoot: begin
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[wms2d_pkg::RootW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[wms2d_pkg::RootW-2:0], 1'b0};
          end
          if (it_q != 6'd32) sum_q <= {sum_q[63:0], 2'b00};
          it_q <= it_q - 6'd1;
          if (it_q == 6'd0) state_q <= StStep;
        end
        StStep: begin
          stp_q   <= mul_p[31:16];
          state_q <= StDecide;
        end
        StDecide: begin
          if (root_q <= {9'b0, tol_q}) begin
            vel_x_q   <= '0;
            vel_y_q   <= '0;
            arrived_q <= 1'b1;
            state_q   <= StOut;
          end else if ({17'b0, stp_q} >= root_q) begin
            pos_x_q   <= tx_q;
            pos_y_q   <= ty_q;
            vel_x_q   <= '0;
            vel_y_q   <= '0;
            arrived_q <= 1'b1;
            state_q   <= StOut;
          end else begin
            arrived_q <= 1'b0;
            dsel_q    <= 2'd0;
            state_q   <= StDiv;
          end
        end
        StDiv: state_q <= StDivWait;
        StDivWait: if (div_done) begin
          case (dsel_q)
            2'd0: dpx_q <= qs;
            2'd1: dpy_q <= qs;
            2'd2: vel_x_q <= qs[wms2d_pkg::VelW-1:0];
            default: vel_y_q <= qs[wms2d_pkg::VelW-1:0];
          endcase
          dsel_q <= dsel_q + 2'd1;
          if (dsel_q == 2'd3) begin
            pos_x_q <= pos_x_q + dpx_q;
            pos_y_q <= pos_y_q + dpy_q;
            state_q <= StOut;
          end else begin
            state_q <= StDiv;
          end
        end
        StOut: if (m_axis_tready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tuser  = arrived_q;
  assign m_axis_tdata  = {6'b0, vel_y_q, vel_x_q, pos_y_q, pos_x_q};

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
  a_root_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> ({17'b0, stp_q} < root_q)) else $error("div by short root");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("out moved");
endmodule

>>> test/waypoint_move_step_2d_unit_tb.sv
// Testbench for waypoint_move_step_2d_unit: runs directed and random load/step words through
// the stream ports under several register settings and compares each result word field by
// field with an in-bench prediction. Depends on wms2d_pkg and the unit RTL.
`timescale 1ns / 100ps

module waypoint_move_step_2d_unit_tb;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic                       op;
    logic [wms2d_pkg::PosW-1:0] tx;
    logic [wms2d_pkg::PosW-1:0] ty;
  } move_cmd_t;

  typedef struct packed {
    logic                       arrived;
    logic [wms2d_pkg::PosW-1:0] px;
    logic [wms2d_pkg::PosW-1:0] py;
    logic [wms2d_pkg::VelW-1:0] vx;
    logic [wms2d_pkg::VelW-1:0] vy;
  } move_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // target_x, target_y
  logic s_axis_tuser = 1'b0;        // operation
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;       // position_x, position_y, velocity_x, velocity_y, zeros
  logic m_axis_tuser;               // arrived
  logic cfg_we_i = 1'b0;
  logic [wms2d_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [wms2d_pkg::CfgDatW-1:0] cfg_data_i = '0;

  waypoint_move_step_2d_unit dut (.*);

  move_cmd_t pending_cmds[$];
  move_res_t expected_moves[$];
  logic [wms2d_pkg::SpdW-1:0] speed_reg;
  logic [wms2d_pkg::TolW-1:0] tol_reg;
  logic [wms2d_pkg::TickW-1:0] tick_reg;
  logic signed [wms2d_pkg::PosW-1:0] cur_x, cur_y;
  logic signed [wms2d_pkg::VelW-1:0] cur_vx, cur_vy;
  int send_idle = 0;
  int recv_idle = 0;
  bit word_taken = 1'b0;
  bit failed = 1'b0;
  int unsigned cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [wms2d_pkg::RootW-1:0] floor_root(logic [65:0] v);
    logic [wms2d_pkg::RootW-1:0] r;
    logic [39:0] rem;
    logic [39:0] trial;
    r = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = {rem[37:0], v[2*i +: 2]};
      trial = {5'b0, r, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        r = {r[wms2d_pkg::RootW-2:0], 1'b1};
      end else begin
        r = {r[wms2d_pkg::RootW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic signed [wms2d_pkg::DiffW-1:0] ratio_scale(
      logic signed [wms2d_pkg::DiffW-1:0] v, logic [16:0] k,
      logic [wms2d_pkg::RootW-1:0] d);
    longint unsigned m;
    longint unsigned q;
    m = v < 0 ? 64'(-v) : 64'(v);
    q = (m * 64'(k)) / 64'(d);
    return v < 0 ? -wms2d_pkg::DiffW'(q) : wms2d_pkg::DiffW'(q);
  endfunction

  function automatic move_res_t advance_position(move_cmd_t c);
    move_res_t r;
    logic signed [wms2d_pkg::DiffW-1:0] dx, dy;
    logic [wms2d_pkg::DiffW-1:0] ax, ay;
    logic [65:0] sq;
    logic [wms2d_pkg::RootW-1:0] gap;
    logic [31:0] prod;
    logic [16:0] stride;
    r.arrived = 1'b0;
    if (c.op == wms2d_pkg::OpLoad) begin
      cur_x = c.tx;
      cur_y = c.ty;
    end else begin
      dx = $signed({c.tx[31], c.tx}) - $signed({cur_x[31], cur_x});
      dy = $signed({c.ty[31], c.ty}) - $signed({cur_y[31], cur_y});
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      gap = floor_root(sq);
      prod = speed_reg * tick_reg;
      stride = 17'(prod >> 16);
      if (gap <= 33'(tol_reg)) begin
        cur_vx = '0;
        cur_vy = '0;
        r.arrived = 1'b1;
      end else if (33'(stride) >= gap) begin
        cur_x = c.tx;
        cur_y = c.ty;
        cur_vx = '0;
        cur_vy = '0;
        r.arrived = 1'b1;
      end else begin
        cur_x = cur_x + 32'(ratio_scale(dx, stride, gap));
        cur_y = cur_y + 32'(ratio_scale(dy, stride, gap));
        cur_vx = 17'(ratio_scale(dx, 17'(speed_reg), gap));
        cur_vy = 17'(ratio_scale(dy, 17'(speed_reg), gap));
      end
    end
    r.px = cur_x;
    r.py = cur_y;
    r.vx = cur_vx;
    r.vy = cur_vy;
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
    if (!s_axis_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (rst_ni && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_cmds[0].op;
        s_axis_tdata <= {pending_cmds[0].ty, pending_cmds[0].tx};
        void'(pending_cmds.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    move_cmd_t c;
    move_res_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c.op = s_axis_tuser;
      c.tx = s_axis_tdata[31:0];
      c.ty = s_axis_tdata[63:32];
      expected_moves.push_back(advance_position(c));
      word_taken = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_moves.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        e = expected_moves.pop_front();
        if (m_axis_tuser !== e.arrived) begin
          $error("arrived: expected %0d, got %0d", e.arrived, m_axis_tuser);
          failed = 1'b1;
        end
        if (m_axis_tdata[31:0] !== e.px) begin
          $error("position_x: expected %h, got %h", e.px, m_axis_tdata[31:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[63:32] !== e.py) begin
          $error("position_y: expected %h, got %h", e.py, m_axis_tdata[63:32]);
          failed = 1'b1;
        end
        if (m_axis_tdata[80:64] !== e.vx) begin
          $error("velocity_x: expected %h, got %h", e.vx, m_axis_tdata[80:64]);
          failed = 1'b1;
        end
        if (m_axis_tdata[97:81] !== e.vy) begin
          $error("velocity_y: expected %h, got %h", e.vy, m_axis_tdata[97:81]);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(logic [wms2d_pkg::CfgIdxW-1:0] idx,
                           logic [wms2d_pkg::CfgDatW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      wms2d_pkg::RegSpeed: speed_reg = val[wms2d_pkg::SpdW-1:0];
      wms2d_pkg::RegTol: tol_reg = val;
      wms2d_pkg::RegTick: tick_reg = val[wms2d_pkg::TickW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [wms2d_pkg::SpdW-1:0] spd, logic [wms2d_pkg::TolW-1:0] tol,
                          logic [wms2d_pkg::TickW-1:0] tick);
    write_reg(wms2d_pkg::RegSpeed, spd);
    write_reg(wms2d_pkg::RegTol, tol);
    write_reg(wms2d_pkg::RegTick, tick);
  endtask

  task automatic queue_cmd(logic op, logic [31:0] x, logic [31:0] y);
    move_cmd_t c;
    c.op = op;
    c.tx = x;
    c.ty = y;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [31:0] rand_offset();
    int w;
    w = $urandom_range(31, 1);
    return $signed($urandom) >>> (32 - w);
  endfunction

  // mostly approach runs: load a start point, then steps toward a nearby target
  task automatic queue_random(int n);
    logic [31:0] bx, by, gx, gy;
    int k;
    while (n > 0) begin
      if ($urandom_range(9) < 2) begin
        queue_cmd(1'($urandom), $urandom, $urandom);
        n--;
      end else begin
        bx = $urandom;
        by = $urandom;
        gx = bx + rand_offset();
        gy = by + rand_offset();
        queue_cmd(wms2d_pkg::OpLoad, bx, by);
        k = $urandom_range(8, 1);
        for (int i = 0; i < k; i++) queue_cmd(wms2d_pkg::OpStep, gx, gy);
        n -= k + 1;
      end
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_moves.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    speed_reg = wms2d_pkg::SpeedRst;
    tol_reg = wms2d_pkg::TolRst;
    tick_reg = wms2d_pkg::TickRst;
    cur_x = '0;
    cur_y = '0;
    cur_vx = '0;
    cur_vy = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 8;
    recv_idle = 73;

    // reset settings: tolerance hit, slow moves, longest distances
    queue_cmd(wms2d_pkg::OpStep, 32'd0, 32'd100);
    queue_cmd(wms2d_pkg::OpStep, 32'd1000, 32'd0);
    queue_cmd(wms2d_pkg::OpStep, 32'hFFFF_FF00, 32'hFFFF_0000);
    queue_cmd(wms2d_pkg::OpLoad, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_cmd(wms2d_pkg::OpStep, 32'h8000_0000, 32'h8000_0000);
    queue_cmd(wms2d_pkg::OpLoad, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_cmd(wms2d_pkg::OpStep, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_cmd(wms2d_pkg::OpStep, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    // extreme speed and tick, zero tolerance: snap, exact hit, big moves
    set_regs(16'hFFFF, 24'd0, 16'hFFFF);
    queue_cmd(wms2d_pkg::OpLoad, 32'd0, 32'd0);
    queue_cmd(wms2d_pkg::OpStep, 32'd0, 32'd0);
    queue_cmd(wms2d_pkg::OpStep, 32'd1000, 32'hFFFF_FC18);
    queue_cmd(wms2d_pkg::OpStep, 32'd1000, 32'hFFFF_FC18);
    queue_cmd(wms2d_pkg::OpStep, 32'd1001, 32'hFFFF_FC18);
    queue_cmd(wms2d_pkg::OpStep, 32'h0100_0000, 32'd0);
    queue_cmd(wms2d_pkg::OpLoad, 32'h8000_0000, 32'h8000_0000);
    queue_cmd(wms2d_pkg::OpStep, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_random(190);
    drain();

    // zero speed, largest tolerance, smallest nonzero tick
    set_regs(16'd0, 24'hFF_FFFF, 16'd1);
    queue_cmd(wms2d_pkg::OpStep, 32'd0, 32'd0);
    queue_cmd(wms2d_pkg::OpLoad, 32'd0, 32'd0);
    queue_cmd(wms2d_pkg::OpStep, 32'h0100_0000, 32'd0);
    queue_cmd(wms2d_pkg::OpStep, 32'h8000_0000, 32'h8000_0000);
    queue_random(190);
    drain();

    set_regs(16'd0, 24'd0, 16'd1);
    queue_cmd(wms2d_pkg::OpStep, 32'h0000_0100, 32'hFFFF_FF00);
    queue_random(150);
    drain();

    send_idle = 73;
    recv_idle = 8;
    set_regs(16'hFFFF, 24'd0, 16'd1);
    queue_random(200);
    drain();
    set_regs(wms2d_pkg::SpeedRst, wms2d_pkg::TolRst, wms2d_pkg::TickRst);
    queue_random(200);
    drain();

    send_idle = 0;
    recv_idle = 0;
    for (int p = 0; p < 3; p++) begin
      set_regs(16'($urandom), 24'($urandom_range(4095)), 16'($urandom_range(65535, 1)));
      queue_random(160);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
